### sv/hws_pkg.sv
// ----------------------------------------------------------------------------
// hws_pkg
// Shared types and constants of the helicity window scaler event builder.
// ----------------------------------------------------------------------------
package hws_pkg;

	localparam int CNT_W       = 31;
	localparam int WORD_W      = 32;
	localparam int FLAGS_W     = 8;
	localparam int WIDX_W      = 3;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CNT_W-1:0]  TIME_STEP = CNT_W'(8);
	localparam logic [3:0]        HDR_TAG   = 4'd12;
	localparam logic [3:0]        HDR_TYPE  = 4'd9;
	localparam logic [WORD_W-1:0] HDR_WORD  = {1'b1, HDR_TAG, HDR_TYPE, 23'd0};
	localparam logic [WORD_W-1:0] END_WORD  = 32'hFFFF_FFFF;

	// position of a word inside an event; later codes all give the end word
	localparam logic [WIDX_W-1:0] WIDX_HEADER = 3'd0;
	localparam logic [WIDX_W-1:0] WIDX_WINDOW = 3'd1;
	localparam logic [WIDX_W-1:0] WIDX_LIVE   = 3'd2;
	localparam logic [WIDX_W-1:0] WIDX_BUSY   = 3'd3;
	localparam logic [WIDX_W-1:0] WIDX_EDGES  = 3'd4;
	localparam logic [WIDX_W-1:0] WIDX_END    = 3'd5;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              last;
	} entry_t;

	typedef struct packed {
		logic   push;
		entry_t data;
	} q_wr_t;

	typedef struct packed {
		logic   valid;
		entry_t data;
	} q_rd_t;

endpackage

### sv/hws_in_if.sv
// ----------------------------------------------------------------------------
// hws_in_if
// Frame channel: one beat carries the levels and hit flags of one frame.
// ----------------------------------------------------------------------------
interface hws_in_if;
	import hws_pkg::*;

	logic               valid;
	logic               ready;
	logic               window_level;
	logic               busy_level;
	logic               hits_valid;
	logic [FLAGS_W-1:0] hit_flags;

	modport source (
		output valid, window_level, busy_level, hits_valid, hit_flags,
		input  ready
	);

	modport sink (
		input  valid, window_level, busy_level, hits_valid, hit_flags,
		output ready
	);

endinterface

### sv/hws_out_if.sv
// ----------------------------------------------------------------------------
// hws_out_if
// Event word channel: one beat carries one event word and its end flag.
// ----------------------------------------------------------------------------
interface hws_out_if;
	import hws_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] word;
	logic              last;

	modport source (
		output valid, word, last,
		input  ready
	);

	modport sink (
		input  valid, word, last,
		output ready
	);

endinterface

### sv/hws_front.sv
// ----------------------------------------------------------------------------
// hws_front
// Accepts frames, updates the scalers, snapshots them and selects the
// event word that each frame produces.
// ----------------------------------------------------------------------------
module hws_front (
	input  logic           clk,
	input  logic           arst_n,
	hws_in_if.sink         frames,
	input  logic           q_full,
	output hws_pkg::q_wr_t q_wr
);
	import hws_pkg::*;

	logic              prev_window_q;
	logic              prev_hit_q;
	logic [CNT_W-1:0]  window_count_q;
	logic [CNT_W-1:0]  busy_time_q;
	logic [CNT_W-1:0]  live_time_q;
	logic [CNT_W-1:0]  edge_count_q;
	logic              emitting_q;
	logic [WIDX_W-1:0] word_index_q;
	logic [CNT_W-1:0]  snap_q [4];

	logic              accept;
	logic              hit;
	logic              inc;
	logic [CNT_W-1:0]  window_nxt;
	logic [CNT_W-1:0]  busy_nxt;
	logic [CNT_W-1:0]  live_nxt;
	logic [CNT_W-1:0]  edge_nxt;
	entry_t            sel;

	assign frames.ready = !q_full;
	assign accept       = frames.valid && frames.ready;
	assign hit          = |frames.hit_flags;
	assign inc          = frames.hits_valid && hit && !prev_hit_q;

	always_comb begin
		window_nxt = window_count_q;
		if (frames.window_level && !prev_window_q)
			window_nxt = window_count_q + CNT_W'(1);
		busy_nxt = busy_time_q;
		live_nxt = live_time_q;
		edge_nxt = edge_count_q;
		if (frames.window_level) begin
			busy_nxt = '0;
			live_nxt = '0;
			edge_nxt = '0;
		end else begin
			if (frames.busy_level)
				busy_nxt = busy_time_q + TIME_STEP;
			else
				live_nxt = live_time_q + TIME_STEP;
			if (inc)
				edge_nxt = edge_count_q + CNT_W'(1);
		end
	end

	always_comb begin
		sel.last = 1'b0;
		unique case (word_index_q)
			WIDX_HEADER: sel.word = HDR_WORD;
			WIDX_WINDOW: sel.word = {1'b0, snap_q[0]};
			WIDX_LIVE:   sel.word = {1'b0, snap_q[1]};
			WIDX_BUSY:   sel.word = {1'b0, snap_q[2]};
			WIDX_EDGES:  sel.word = {1'b0, snap_q[3]};
			default: begin
				sel.word = END_WORD;
				sel.last = 1'b1;
			end
		endcase
	end

	assign q_wr.push = accept && emitting_q;
	assign q_wr.data = sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_window_q  <= 1'b1;
			prev_hit_q     <= 1'b0;
			window_count_q <= '0;
			busy_time_q    <= '0;
			live_time_q    <= '0;
			edge_count_q   <= '0;
			emitting_q     <= 1'b0;
			word_index_q   <= WIDX_HEADER;
		end else if (accept) begin
			prev_window_q  <= frames.window_level;
			if (frames.hits_valid)
				prev_hit_q <= hit;
			window_count_q <= window_nxt;
			busy_time_q    <= busy_nxt;
			live_time_q    <= live_nxt;
			edge_count_q   <= edge_nxt;
			if (!emitting_q) begin
				emitting_q <= 1'b1;
			end else if (sel.last) begin
				emitting_q   <= 1'b0;
				word_index_q <= WIDX_HEADER;
			end else begin
				word_index_q <= word_index_q + WIDX_W'(1);
			end
		end
	end

	// snapshot takes the counters as updated by this frame
	always_ff @(posedge clk) begin
		if (accept && !emitting_q) begin
			snap_q[0] <= window_nxt;
			snap_q[1] <= live_nxt;
			snap_q[2] <= busy_nxt;
			snap_q[3] <= edge_nxt;
		end
	end

`ifndef ASSERT_OFF
	a_snap_starts_event: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !emitting_q |=> emitting_q && word_index_q == WIDX_HEADER)
		else $error("snapshot frame did not start an event at the header");
	a_end_closes_event: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr.push && q_wr.data.last |=> !emitting_q)
		else $error("end word did not close the event");
	a_idle_index: assert property (@(posedge clk) disable iff (!arst_n)
		!emitting_q |-> word_index_q == WIDX_HEADER)
		else $error("word index nonzero between events");
	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		emitting_q |-> word_index_q <= WIDX_END)
		else $error("word index ran past the end word");
`endif

endmodule

### sv/hws_queue.sv
// ----------------------------------------------------------------------------
// hws_queue
// Short FIFO of event words between the front and the output stage.
// ----------------------------------------------------------------------------
module hws_queue #(
	parameter int DEPTH = hws_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  hws_pkg::q_wr_t q_wr,
	output logic           q_full,
	input  logic           pop,
	output hws_pkg::q_rd_t q_rd
);
	import hws_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_QW = $clog2(DEPTH + 1);

	entry_t            mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign q_full     = (count_q == CNT_QW'(DEPTH));
	assign q_rd.valid = (count_q != '0);
	assign q_rd.data  = mem_q[rd_ptr_q];
	assign do_push    = q_wr.push && !q_full;
	assign do_pop     = pop && q_rd.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_QW'(1);
				2'b01:   count_q <= count_q - CNT_QW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= q_wr.data;
	end

`ifndef ASSERT_OFF
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_wr.push)
		else $error("push into a full queue");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> count_q == $past(count_q) + CNT_QW'(1))
		else $error("queue count did not follow a push");
	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop && !do_push |=> count_q == $past(count_q) - CNT_QW'(1))
		else $error("queue count did not follow a pop");
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_QW'(DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

### sv/hws_back.sv
// ----------------------------------------------------------------------------
// hws_back
// Output stage: pulls event words from the queue into a register and
// hands them out on the word channel.
// ----------------------------------------------------------------------------
module hws_back (
	input  logic           clk,
	input  logic           arst_n,
	input  hws_pkg::q_rd_t q_rd,
	output logic           pop,
	hws_out_if.source      words
);
	import hws_pkg::*;

	logic   valid_q;
	entry_t data_q;

	// refill when empty or when the held beat leaves this cycle
	assign pop = q_rd.valid && (!valid_q || words.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop)
			valid_q <= 1'b1;
		else if (words.ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop)
			data_q <= q_rd.data;
	end

	assign words.valid = valid_q;
	assign words.word  = data_q.word;
	assign words.last  = data_q.last;

`ifndef ASSERT_OFF
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !words.ready |=> valid_q && $stable(data_q))
		else $error("stalled beat changed");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> valid_q && data_q == $past(q_rd.data))
		else $error("output register missed a queue word");
	a_pop_gate: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !words.ready |-> !pop)
		else $error("pop while output stalled");
`endif

endmodule

### sv/helicity_window_scaler_event_builder.sv
// Path: a frame that selects an event word pushes it into the queue, from which
// it moves to the output register; a snapshot frame produces no word.
// Throughput: one frame per cycle while the queue is not full; each event takes
// seven frames and yields six words, buffered by a QUEUE_DEPTH-entry queue ahead
// of the output register. Reset: arst_n clears all scalers, the event sequencer
// and the queue at once; the snapshot registers are loaded by the first frame.
// ----------------------------------------------------------------------------
// helicity_window_scaler_event_builder
// Helicity window scalers with a free-running six-word event builder.
// ----------------------------------------------------------------------------
module helicity_window_scaler_event_builder #(
	parameter int QUEUE_DEPTH = hws_pkg::QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	hws_in_if.sink    frames,
	hws_out_if.source words
);
	import hws_pkg::*;

	q_wr_t q_wr;
	q_rd_t q_rd;
	logic  q_full;
	logic  pop;

	hws_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.frames (frames),
		.q_full (q_full),
		.q_wr   (q_wr)
	);

	hws_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.q_full (q_full),
		.pop    (pop),
		.q_rd   (q_rd)
	);

	hws_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_rd   (q_rd),
		.pop    (pop),
		.words  (words)
	);

endmodule
